>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int ValueW = 32;
   localparam int PrioW  = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_REMOVED  = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic signed [ValueW-1:0] value;
      logic signed [PrioW-1:0]  prio;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;   // accepted insert with room to spare
      logic remove;   // accepted removal with something stored
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it with the incoming
// priority and takes data from the left, from the right or from the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic                  clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire spq_pkg::entry_type    new_entry,
   input  wire logic                  occupied,
   input  wire logic                  left_occupied,
   input  wire logic                  left_displace,
   input  wire spq_pkg::entry_type    left_entry,
   input  wire spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type         entry,
   output logic                       displace
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               open_slot;

   // entry must move right when the newcomer outranks it
   assign displace  = occupied && (entry_ff.prio < new_entry.prio);
   assign open_slot = displace || !occupied;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.remove) begin
         entry_in = right_entry;
      end else if (ctrl.insert && open_slot && left_displace) begin
         entry_in = left_entry;
      end else if (ctrl.insert && open_slot && left_occupied) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a row of cells sorted by priority.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ word is an insert (value with priority) or a removal of the
//   highest-priority entry. Equal priorities leave in arrival order.
//   Every request gives exactly one rsp_ word: status, removed value (zero
//   unless removed), occupancy and full/empty flags after the operation.
//   rsp_valid rises the cycle after request acceptance. Throughput is one
//   word per cycle while req_stall is low: all cells compare against the
//   new priority and shift left or right together when a word is accepted.
//   The result sits in an output register; a new request is taken while
//   that register is empty or being emptied. While rsp_stall holds a full
//   output register, req_stall is raised and the queue holds its state.
//   Reset (synchronous) empties the queue and drops any pending result;
//   entry contents are not cleared, as only occupied cells are ever read.
//   Occupancy is reported modulo 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
   parameter int DEPTH = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_op,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [15:0] req_priority_req,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [1:0]  rsp_status,
   output logic signed      [31:0] rsp_removed_value,
   output logic             [3:0]  rsp_occupancy,
   output logic                    rsp_is_full,
   output logic                    rsp_is_empty
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   logic [CntW-1:0]        count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic signed [31:0]     removed_ff, removed_in;
   logic [CntW-1:0]        occ_ff;
   logic [31:0]            occ_ext;

   logic                   accept;
   logic                   is_full_now;
   logic                   is_empty_now;
   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::entry_type     new_entry;
   spq_pkg::entry_type     cell_entry [DEPTH];
   logic                   cell_disp  [DEPTH];
   logic                   cell_occ   [DEPTH];

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign is_full_now  = (count_ff == CntFull);
   assign is_empty_now = (count_ff == '0);

   assign ctrl.insert = accept && (req_op == spq_pkg::OP_INSERT) && !is_full_now;
   assign ctrl.remove = accept && (req_op == spq_pkg::OP_REMOVE) && !is_empty_now;

   assign new_entry.value = req_value;
   assign new_entry.prio  = req_priority_req;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_e, right_e;
      logic               left_occ, left_disp;

      assign cell_occ[i] = (CntW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_e    = new_entry;
         assign left_occ  = 1'b1;
         assign left_disp = 1'b0;
      end else begin : g_body
         assign left_e    = cell_entry[i-1];
         assign left_occ  = cell_occ[i-1];
         assign left_disp = cell_disp[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_mid
         assign right_e = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .new_entry     (new_entry),
         .occupied      (cell_occ[i]),
         .left_occupied (left_occ),
         .left_displace (left_disp),
         .left_entry    (left_e),
         .right_entry   (right_e),
         .entry         (cell_entry[i]),
         .displace      (cell_disp[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      removed_in   = removed_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         unique case (req_op)
            spq_pkg::OP_INSERT: begin
               if (is_full_now) begin
                  status_in = spq_pkg::ST_FULL;
               end else begin
                  status_in = spq_pkg::ST_INSERTED;
                  count_in  = count_ff + CntW'(1);
               end
            end
            spq_pkg::OP_REMOVE: begin
               if (is_empty_now) begin
                  status_in = spq_pkg::ST_EMPTY;
               end else begin
                  status_in  = spq_pkg::ST_REMOVED;
                  removed_in = cell_entry[0].value;
                  count_in   = count_ff - CntW'(1);
               end
            end
            default: status_in = status_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         occ_ff     <= count_in;
      end
   end

   assign occ_ext           = 32'(occ_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_occupancy     = occ_ext[3:0];
   assign rsp_is_full       = (occ_ff == CntFull);
   assign rsp_is_empty      = (occ_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("entry count beyond depth");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (occ_ff == count_ff))
      else $error("accepted word gave no result or wrong occupancy");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == spq_pkg::ST_FULL) |-> rsp_is_full)
      else $error("rejected insert without full flag");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_is_empty |->
         (status_ff == spq_pkg::ST_REMOVED) || (status_ff == spq_pkg::ST_EMPTY))
      else $error("empty queue after an insert");

endmodule

`default_nettype wire

>>> sim/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Each accepted req_ word goes through a behavioural copy of the queue and its
// predicted rsp_ word is queued. Every rsp_ word taken is compared field by
// field with the oldest prediction. Directed words cover the empty and full
// corners and equal-priority ordering. Random traffic then swings between
// filling and draining. Both sides idle at random, and the receiver once
// holds off long enough to back the queue up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

   localparam int QueueDepth = 8;
   localparam int QuietLimit = 3000;   // cycles without any word moving
   localparam int LongHold   = 300;

   typedef struct packed {
      logic [1:0]                 status;
      logic [spq_pkg::ValueW-1:0] removed_value;
      logic [3:0]                 occupancy;
      logic                       is_full;
      logic                       is_empty;
   } queue_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_op = spq_pkg::OP_INSERT;
   logic signed [spq_pkg::ValueW-1:0] req_value = '0;
   logic signed [spq_pkg::PrioW-1:0]  req_priority_req = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [1:0]                       rsp_status;
   logic signed [31:0]               rsp_removed_value;
   logic [3:0]                       rsp_occupancy;
   logic                             rsp_is_full;
   logic                             rsp_is_empty;

   // behavioural copy of the queue contents
   spq_pkg::entry_type held_entries [QueueDepth];
   int                 held_count = 0;
   queue_result_type   pending_results [$];

   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  idle_off = 1'b0;
   int  rsp_hold_request = 0;

   sorted_priority_queue #(.DEPTH(QueueDepth)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_is_full       (rsp_is_full),
      .rsp_is_empty      (rsp_is_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_draw();
      return idle_off ? 0 : $urandom_range(13, 0);
   endfunction

   // apply one operation to the model queue and return the word it gives
   function automatic queue_result_type queue_apply(
         logic op, logic signed [spq_pkg::ValueW-1:0] val,
         logic signed [spq_pkg::PrioW-1:0] pri);
      queue_result_type r;
      int               pos;
      r = '0;
      if (op == spq_pkg::OP_INSERT) begin
         if (held_count >= QueueDepth) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            pos = held_count;
            // new entry goes behind all of equal or higher priority
            while (pos > 0 && $signed(held_entries[pos-1].prio) < pri) begin
               held_entries[pos] = held_entries[pos-1];
               pos--;
            end
            held_entries[pos].value = val;
            held_entries[pos].prio  = pri;
            held_count++;
            r.status = spq_pkg::ST_INSERTED;
         end
      end else begin
         if (held_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.removed_value = held_entries[0].value;
            for (int k = 0; k + 1 < held_count; k++)
               held_entries[k] = held_entries[k+1];
            held_count--;
            r.status = spq_pkg::ST_REMOVED;
         end
      end
      r.occupancy = 4'(held_count);
      r.is_full   = (held_count == QueueDepth);
      r.is_empty  = (held_count == 0);
      return r;
   endfunction

   task automatic send_word(logic op, logic signed [spq_pkg::ValueW-1:0] val,
                            logic signed [spq_pkg::PrioW-1:0] pri);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_value        <= val;
      req_priority_req <= pri;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(queue_apply(op, val, pri));
   endtask

   function automatic logic signed [spq_pkg::PrioW-1:0] random_priority();
      int pick;
      pick = $urandom_range(9, 0);
      if (pick < 4) return spq_pkg::PrioW'($signed($urandom_range(4, 0)) - 2);
      if (pick < 6) begin
         case ($urandom_range(3, 0))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return spq_pkg::PrioW'($urandom);
   endfunction

   function automatic logic signed [spq_pkg::ValueW-1:0] random_value();
      case ($urandom_range(15, 0))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0000_0000;
         3: return 32'shFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // one random word; insert_pct biases towards filling or draining
   task automatic send_random(int insert_pct);
      logic op;
      op = ($urandom_range(99, 0) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
      send_word(op, random_value(), random_priority());
   endtask

   task automatic test_empty_and_full_corners();
      send_word(spq_pkg::OP_REMOVE, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_word(spq_pkg::OP_REMOVE, 32'shFFFF_FFFF, 16'shFFFF);
      send_word(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'sh0000);
      send_word(spq_pkg::OP_INSERT, 32'sh8000_0000, 16'sh0000);
      send_word(spq_pkg::OP_INSERT, 32'sh0000_0000, 16'sh7FFF);
      send_word(spq_pkg::OP_INSERT, 32'shFFFF_FFFF, 16'sh8000);
      send_word(spq_pkg::OP_INSERT, 32'sh1234_5678, 16'sh0000);
      send_word(spq_pkg::OP_INSERT, 32'sh5555_5555, 16'sh0001);
      send_word(spq_pkg::OP_INSERT, 32'shAAAA_AAAA, 16'shFFFF);
      send_word(spq_pkg::OP_INSERT, 32'sh0000_0001, 16'sh7FFF);
      // queue full now: both rejected
      send_word(spq_pkg::OP_INSERT, 32'sh0000_0063, 16'sh7FFF);
      send_word(spq_pkg::OP_INSERT, 32'shFFFF_FFFF, 16'shFFFF);
      repeat (QueueDepth + 1) send_word(spq_pkg::OP_REMOVE, '0, '0);
   endtask

   task automatic test_random_traffic();
      int pct;
      for (int blk = 0; blk < 26; blk++) begin
         case (blk % 3)
            0: pct = 75;
            1: pct = 50;
            default: pct = 25;
         endcase
         repeat (50) send_random(pct);
      end
   endtask

   task automatic test_output_backpressure();
      rsp_hold_request = LongHold;
      repeat (40) send_random(60);
   endtask

   task automatic test_drain_pause();
      repeat (15) send_random(70);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      @(posedge clock);
      repeat (15) send_random(40);
   endtask

   task automatic test_back_to_back();
      idle_off = 1'b1;
      repeat (40) send_random(70);
      repeat (40) send_random(30);
      idle_off = 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("rsp_ word with nothing outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("removed_value", want.removed_value, rsp_removed_value);
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            check_field("is_full", 32'(want.is_full), 32'(rsp_is_full));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
         end
      end
   end

   // receiver: a fresh stall length per word, or one long hold on request
   initial begin : rsp_side
      int wait_cycles;
      forever begin
         if (rsp_hold_request > 0) begin
            wait_cycles      = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            wait_cycles = idle_draw();
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_full_corners();
      test_random_traffic();
      test_output_backpressure();
      test_drain_pause();
      test_back_to_back();
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
